FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the cave automaton block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define CAS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent holds.
`define CAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/cas_pkg.sv
// Package of the cave automaton step block: sizes, register indexes and rule constants.
package cas_pkg;

  localparam int MAX_COLUMNS = 256;
  localparam int MAX_ROWS    = 256;
  localparam int MIN_DIM     = 5;
  localparam int DIM_RESET   = 65;

  // Two padding columns and rows follow the grid.
  localparam int HALO     = 2;
  localparam int LINE_LEN = MAX_COLUMNS + HALO;
  localparam int COL_W    = $clog2(MAX_COLUMNS + HALO);
  localparam int ROW_W    = $clog2(MAX_ROWS + HALO);

  localparam int DIM_W     = 9;
  localparam int CFG_IDX_W = 2;

  localparam int WIN_SIDE   = 5;
  localparam int WIN_BITS   = WIN_SIDE * WIN_SIDE;
  localparam int LINE_ROWS  = WIN_SIDE - 1;
  localparam int CENTER_BIT = (WIN_BITS - 1) / 2;

  localparam int WALL_MIN_3X3  = 5;
  localparam int SPARSE_MAX_5X5 = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_EARLY_FILL  = 2'd2
  } reg_idx_e;

endpackage

FILE: rtl/cas_intf.sv
// Valid/ready channel interfaces of the cave automaton step block.
interface cas_cell_if;
  logic valid;
  logic ready;
  logic cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink (input valid, input cell_value, output ready);
endinterface

interface cas_result_if;
  logic valid;
  logic ready;
  logic new_value;
  logic last_cell;

  modport source (output valid, output new_value, output last_cell, input ready);
  modport sink (input valid, input new_value, input last_cell, output ready);
endinterface

interface cas_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cas_pkg::CFG_IDX_W-1:0] index;
  logic [cas_pkg::DIM_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/cas_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cas_ram #(
  parameter int WIDTH  = 1,
  parameter int DEPTH  = 2,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/cave_automaton_step.sv
// Cave automaton step: one streaming smoothing pass over a binary wall grid.
//
// cell_i takes the frame in raster order: each grid row is followed by two
// padding columns and the grid by two padding rows, (W+2) x (H+2) requests in
// all. Padding values are ignored. result_o gives one new cell for every frame
// position at row >= 2 and column >= 2, in raster order of the grid; last_cell
// marks the final grid cell. cfg_i writes grid_width (0), grid_height (1) and
// early_fill (2); dimensions saturate into the legal range and restart the frame.
//
// Throughput: one request per cycle while result_o is not stalled. A line
// memory of (MAX_COLUMNS+2) words of four bits keeps the last four rows of
// each column; it has one read and one write port, and is read when a request
// is accepted and written when that request leaves the compute stage, which
// waits while the output stalls. The request that completes a window passes
// the compute stage register and then the output register to result_o.
// When result_o stalls, the output register holds its result and the compute
// stage takes up to the next request with a result; further requests wait.
// Reset clears counters, window and pipeline valids and sets 65 x 65 with
// early fill on; the line memory needs no clearing.
module cave_automaton_step (
  input  logic         clk_i,
  input  logic         rst_ni,
  cas_cell_if.sink     cell_i,
  cas_result_if.source result_o,
  cas_cfg_if.sink      cfg_i
);

  `include "assert_macros.svh"

  localparam int ColW = cas_pkg::COL_W;
  localparam int RowW = cas_pkg::ROW_W;

  function automatic logic [ColW-1:0] clamp_cols(logic [cas_pkg::DIM_W-1:0] v);
    logic [ColW-1:0] res;
    if (32'(v) < cas_pkg::MIN_DIM) begin
      res = ColW'(cas_pkg::MIN_DIM);
    end else if (32'(v) > cas_pkg::MAX_COLUMNS) begin
      res = ColW'(cas_pkg::MAX_COLUMNS);
    end else begin
      res = ColW'(v);
    end
    return res;
  endfunction

  function automatic logic [RowW-1:0] clamp_rows(logic [cas_pkg::DIM_W-1:0] v);
    logic [RowW-1:0] res;
    if (32'(v) < cas_pkg::MIN_DIM) begin
      res = RowW'(cas_pkg::MIN_DIM);
    end else if (32'(v) > cas_pkg::MAX_ROWS) begin
      res = RowW'(cas_pkg::MAX_ROWS);
    end else begin
      res = RowW'(v);
    end
    return res;
  endfunction

  // Configuration
  logic [ColW-1:0] width_q;
  logic [RowW-1:0] height_q;
  logic            fill_q;
  logic            cfg_we;
  logic            restart;
  cas_pkg::reg_idx_e cfg_idx;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;
  assign cfg_idx     = cas_pkg::reg_idx_e'(cfg_i.index);
  assign restart     = cfg_we && (cfg_idx == cas_pkg::REG_GRID_WIDTH ||
                                  cfg_idx == cas_pkg::REG_GRID_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ColW'(cas_pkg::DIM_RESET);
      height_q <= RowW'(cas_pkg::DIM_RESET);
      fill_q   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        cas_pkg::REG_GRID_WIDTH:  width_q  <= clamp_cols(cfg_i.data);
        cas_pkg::REG_GRID_HEIGHT: height_q <= clamp_rows(cfg_i.data);
        cas_pkg::REG_EARLY_FILL:  fill_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Request stage: frame position counters and line memory read
  logic [ColW-1:0] col_cnt_q, col_cnt_d;
  logic [RowW-1:0] row_cnt_q, row_cnt_d;
  logic            accept;
  logic            in_bit;
  logic            s1_adv;

  assign accept = cell_i.valid && cell_i.ready;
  assign in_bit = (col_cnt_q >= width_q || row_cnt_q >= height_q) ? 1'b0 : cell_i.cell_value;

  always_comb begin
    col_cnt_d = col_cnt_q;
    row_cnt_d = row_cnt_q;
    if (restart) begin
      col_cnt_d = '0;
      row_cnt_d = '0;
    end else if (accept) begin
      if (col_cnt_q == width_q + ColW'(1)) begin
        col_cnt_d = '0;
        row_cnt_d = (row_cnt_q == height_q + RowW'(1)) ? '0 : row_cnt_q + RowW'(1);
      end else begin
        col_cnt_d = col_cnt_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else begin
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
    end
  end

  // Compute stage registers
  logic            s1_valid_q;
  logic            s1_bit_q;
  logic [ColW-1:0] s1_col_q;
  logic [RowW-1:0] s1_row_q;

  assign cell_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_bit_q <= in_bit;
      s1_col_q <= col_cnt_q;
      s1_row_q <= row_cnt_q;
    end
  end

  // Word per column: bit k holds row (r-4+k), newest row in the top bit.
  logic [cas_pkg::LINE_ROWS-1:0] line_rd;
  logic [cas_pkg::LINE_ROWS-1:0] line_wr;

  assign line_wr = {s1_bit_q, line_rd[cas_pkg::LINE_ROWS-1:1]};

  cas_ram #(
    .WIDTH (cas_pkg::LINE_ROWS),
    .DEPTH (cas_pkg::LINE_LEN)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (line_wr),
    .re_i    (accept),
    .raddr_i (col_cnt_q),
    .rdata_o (line_rd)
  );

  // Window update and cell rule
  logic [cas_pkg::WIN_BITS-1:0] window_q, window_d;
  logic [cas_pkg::WIN_SIDE-1:0] col_bits;
  logic [3:0]                   cnt3;
  logic [4:0]                   cnt5;
  logic                         has_res;
  logic                         on_border;
  logic                         new_val;
  logic                         last_val;
  logic                         out_free;
  logic                         out_valid_q;
  logic                         new_value_q;
  logic                         last_cell_q;

  always_comb begin
    // Rows above the top of the frame read as empty.
    for (int k = 0; k < cas_pkg::LINE_ROWS; k++) begin
      col_bits[k] = line_rd[k] && (32'(s1_row_q) + k >= cas_pkg::LINE_ROWS);
    end
    col_bits[cas_pkg::WIN_SIDE-1] = s1_bit_q;
    window_d = {col_bits, window_q[cas_pkg::WIN_BITS-1:cas_pkg::WIN_SIDE]};
  end

  always_comb begin
    cnt3 = '0;
    cnt5 = '0;
    for (int i = 1; i <= 3; i++) begin
      for (int j = 1; j <= 3; j++) begin
        cnt3 = cnt3 + 4'(window_d[i*cas_pkg::WIN_SIDE + j]);
      end
    end
    for (int b = 0; b < cas_pkg::WIN_BITS; b++) begin
      cnt5 = cnt5 + 5'(window_d[b]);
    end
  end

  assign has_res   = s1_row_q >= RowW'(cas_pkg::HALO) && s1_col_q >= ColW'(cas_pkg::HALO);
  assign on_border = s1_row_q == RowW'(cas_pkg::HALO) || s1_col_q == ColW'(cas_pkg::HALO) ||
                     s1_row_q == height_q + RowW'(1) || s1_col_q == width_q + ColW'(1);
  assign last_val  = s1_row_q == height_q + RowW'(1) && s1_col_q == width_q + ColW'(1);
  assign new_val   = on_border ? window_d[cas_pkg::CENTER_BIT] :
                     (cnt3 >= 4'(cas_pkg::WALL_MIN_3X3) ||
                      (fill_q && cnt5 <= 5'(cas_pkg::SPARSE_MAX_5X5)));

  assign out_free = !out_valid_q || result_o.ready;
  assign s1_adv   = s1_valid_q && (!has_res || out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (restart) begin
      window_q <= '0;
    end else if (s1_adv) begin
      window_q <= window_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && has_res) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && has_res) begin
      new_value_q <= new_val;
      last_cell_q <= last_val;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.new_value = new_value_q;
  assign result_o.last_cell = last_cell_q;

  `CAS_ASSERT(a_col_in_frame, col_cnt_q <= width_q + ColW'(1), "column counter left the frame")
  `CAS_ASSERT(a_row_in_frame, row_cnt_q <= height_q + RowW'(1), "row counter left the frame")
  `CAS_ASSERT_NEXT(a_restart_clears, restart,
                   col_cnt_q == '0 && row_cnt_q == '0 && window_q == '0,
                   "dimension write did not restart the frame")
  `CAS_ASSERT_NEXT(a_s1_holds, s1_valid_q && !s1_adv,
                   s1_valid_q && $stable(s1_col_q) && $stable(s1_row_q),
                   "stalled compute stage lost its request")

endmodule

FILE: dv/tb_cave_automaton_step.sv
// Self-checking testbench for cave_automaton_step: raster stimulus, cell predictor, result check.
`timescale 1ns / 1ps

module tb_cave_automaton_step;

  localparam int unsigned ITEM_TARGET    = 1200;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned LONG_HOLD_AT   = 100;
  localparam int unsigned LONG_HOLD      = 150;
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int          DRAIN_AT       = 140;
  localparam logic [cas_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef logic [cas_pkg::DIM_W-1:0]     dim_t;
  typedef logic [cas_pkg::CFG_IDX_W-1:0] idx_t;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONE, FILL_CHECKER} fill_kind_e;

  typedef struct {
    logic        value;
    int unsigned gap;
    bit          drain_first;
  } cell_req_t;

  typedef struct packed {
    logic new_value;
    logic last_cell;
  } cell_result_t;

  logic clk_i;
  logic rst_ni;

  cas_cell_if   cell_bus ();
  cas_result_if result_bus ();
  cas_cfg_if    cfg_bus ();

  cave_automaton_step uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cell_i   (cell_bus),
    .result_o (result_bus),
    .cfg_i    (cfg_bus)
  );

  // Predictor state
  logic        row_hist [0:cas_pkg::LINE_ROWS-1][0:cas_pkg::LINE_LEN-1] = '{default: 1'b0};
  logic [cas_pkg::WIN_BITS-1:0] stencil = '0;
  int unsigned scan_col    = 0;
  int unsigned scan_row    = 0;
  int unsigned cols_eff    = cas_pkg::DIM_RESET;
  int unsigned rows_eff    = cas_pkg::DIM_RESET;
  logic        sparse_fill = 1'b1;

  cell_req_t    raster_cells [$];
  cell_result_t smoothed_cells [$];

  int unsigned cells_smoothed = 0;  // NBA-updated, read by driver and sequencer
  int unsigned cells_returned = 0;
  int unsigned cells_sent     = 0;
  int unsigned cells_queued   = 0;
  int unsigned frames_done    = 0;
  int unsigned reg_writes     = 0;
  int unsigned mismatches     = 0;
  int unsigned gap_count;
  int unsigned ready_wait;
  int unsigned ready_taken;
  int unsigned ready_draw;
  int unsigned quiet_cycles;
  bit          long_hold_done;
  bit          no_idle = 1'b0;

  function automatic int unsigned fit_dim(dim_t raw, int unsigned hi);
    if (raw < cas_pkg::MIN_DIM) return cas_pkg::MIN_DIM;
    if (raw > hi) return hi;
    return raw;
  endfunction

  function automatic dim_t random_dim();
    int unsigned v;
    v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 14);
    return dim_t'(v);
  endfunction

  function automatic void apply_reg(idx_t idx, dim_t val);
    case (idx)
      cas_pkg::REG_GRID_WIDTH: begin
        cols_eff = fit_dim(val, cas_pkg::MAX_COLUMNS);
        scan_col = 0;
        scan_row = 0;
        stencil  = '0;
      end
      cas_pkg::REG_GRID_HEIGHT: begin
        rows_eff = fit_dim(val, cas_pkg::MAX_ROWS);
        scan_col = 0;
        scan_row = 0;
        stencil  = '0;
      end
      cas_pkg::REG_EARLY_FILL: sparse_fill = val[0];
      default: ;
    endcase
  endfunction

  // One raster position in; at most one smoothed cell out.
  function automatic void smooth_cell(input logic in_bit, output bit emitted,
                                      output cell_result_t res);
    int unsigned fr, fc;
    logic        wall;
    logic [cas_pkg::WIN_SIDE-1:0] column;
    int          c3;
    emitted = 1'b0;
    res     = '0;
    if (scan_col >= cols_eff + cas_pkg::HALO || scan_row >= rows_eff + cas_pkg::HALO) begin
      scan_col = 0;
      scan_row = 0;
      stencil  = '0;
    end
    fr   = scan_row;
    fc   = scan_col;
    wall = (fc >= cols_eff || fr >= rows_eff) ? 1'b0 : in_bit;
    // rows above the top of the frame read as empty
    for (int k = 0; k < cas_pkg::LINE_ROWS; k++)
      column[k] = (fr + k >= cas_pkg::LINE_ROWS) ?
                  row_hist[(fr + k) % cas_pkg::LINE_ROWS][fc] : 1'b0;
    column[cas_pkg::WIN_SIDE-1] = wall;
    row_hist[fr % cas_pkg::LINE_ROWS][fc] = wall;
    stencil = {column, stencil[cas_pkg::WIN_BITS-1:cas_pkg::WIN_SIDE]};
    if (fr >= cas_pkg::HALO && fc >= cas_pkg::HALO) begin
      emitted = 1'b1;
      if (fr == cas_pkg::HALO || fc == cas_pkg::HALO || fr == rows_eff + 1 ||
          fc == cols_eff + 1) begin
        res.new_value = stencil[cas_pkg::CENTER_BIT];
      end else begin
        c3 = 0;
        for (int ci = 1; ci <= 3; ci++)
          c3 += $countones(stencil[ci*cas_pkg::WIN_SIDE+1 +: 3]);
        res.new_value = (c3 >= cas_pkg::WALL_MIN_3X3) ||
                        (sparse_fill && $countones(stencil) <= cas_pkg::SPARSE_MAX_5X5);
      end
      res.last_cell = (fr == rows_eff + 1 && fc == cols_eff + 1);
    end
    if (fc + 1 >= cols_eff + cas_pkg::HALO) begin
      scan_col = 0;
      scan_row = (fr + 1 >= rows_eff + cas_pkg::HALO) ? 0 : fr + 1;
    end else begin
      scan_col = fc + 1;
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cell_bus.valid <= 1'b0;
      gap_count      <= 0;
    end else if (!cell_bus.valid || cell_bus.ready) begin
      if (raster_cells.size() == 0) begin
        cell_bus.valid <= 1'b0;
      end else if (gap_count < raster_cells[0].gap) begin
        cell_bus.valid <= 1'b0;
        gap_count      <= gap_count + 1;
      end else if (raster_cells[0].drain_first && cells_smoothed != cells_returned) begin
        cell_bus.valid <= 1'b0;
      end else begin
        cell_bus.valid      <= 1'b1;
        cell_bus.cell_value <= raster_cells[0].value;
        gap_count           <= 0;
        void'(raster_cells.pop_front());
      end
    end
  end

  // Result ready: random stalls after each accepted result, one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
      ready_wait       <= 0;
      ready_taken      <= 0;
      long_hold_done   <= 1'b0;
    end else if (result_bus.valid && result_bus.ready) begin
      ready_taken <= ready_taken + 1;
      if (!long_hold_done && ready_taken == LONG_HOLD_AT) begin
        long_hold_done   <= 1'b1;
        result_bus.ready <= 1'b0;
        ready_wait       <= LONG_HOLD;
      end else begin
        ready_draw = no_idle ? 0 : $urandom_range(0, 3);
        if (ready_draw == 0) begin
          result_bus.ready <= 1'b1;
        end else begin
          result_bus.ready <= 1'b0;
          ready_wait       <= ready_draw - 1;
        end
      end
    end else if (ready_wait > 0) begin
      result_bus.ready <= 1'b0;
      ready_wait       <= ready_wait - 1;
    end else begin
      result_bus.ready <= 1'b1;
    end
  end

  // Monitor: predict on accepted cells, check accepted results
  always @(posedge clk_i) begin
    bit           emitted;
    cell_result_t predicted;
    cell_result_t got;
    if (rst_ni) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        apply_reg(cfg_bus.index, cfg_bus.data);
        reg_writes++;
      end
      if (cell_bus.valid && cell_bus.ready) begin
        cells_sent++;
        smooth_cell(cell_bus.cell_value, emitted, predicted);
        if (emitted) begin
          smoothed_cells.insert(smoothed_cells.size(), predicted);
          cells_smoothed <= cells_smoothed + 1;
        end
      end
      if (result_bus.valid && result_bus.ready) begin
        cells_returned <= cells_returned + 1;
        got.new_value = result_bus.new_value;
        got.last_cell = result_bus.last_cell;
        if (smoothed_cells.size() == 0) begin
          $error("unexpected result: new_value %0b last_cell %0b", got.new_value,
                 got.last_cell);
          mismatches++;
        end else begin
          predicted = smoothed_cells.pop_front();
          if (got.new_value !== predicted.new_value) begin
            $error("new_value: expected %0b, got %0b", predicted.new_value, got.new_value);
            mismatches++;
          end
          if (got.last_cell !== predicted.last_cell) begin
            $error("last_cell: expected %0b, got %0b", predicted.last_cell, got.last_cell);
            mismatches++;
          end
          if (predicted.last_cell) frames_done++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted cell, result or register write
  always @(posedge clk_i) begin
    if (!rst_ni || (cell_bus.valid && cell_bus.ready) ||
        (result_bus.valid && result_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", quiet_cycles);
      $display("tb_cave_automaton_step: errors");
      $finish;
    end
  end

  task automatic write_reg(input idx_t idx, input dim_t val);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic queue_cells(input int unsigned count, input int unsigned density,
                             input fill_kind_e kind, input int drain_at);
    cell_req_t req;
    @(negedge clk_i);
    for (int i = 0; i < count; i++) begin
      case (kind)
        FILL_ZERO:    req.value = 1'b0;
        FILL_ONE:     req.value = 1'b1;
        FILL_CHECKER: req.value = i[0];
        default:      req.value = ($urandom_range(0, 99) < density);
      endcase
      req.gap         = no_idle ? 0 : $urandom_range(0, 3);
      req.drain_first = (i == drain_at) || (kind == FILL_RANDOM && $urandom_range(0, 299) == 0);
      if (req.drain_first && req.gap == 0) req.gap = 1;
      raster_cells.insert(raster_cells.size(), req);
    end
    cells_queued += count;
  endtask

  // Block is idle once everything is sent and answered, plus pipeline settle time
  task automatic wait_idle();
    @(negedge clk_i);
    while (raster_cells.size() != 0 || cell_bus.valid || cells_smoothed != cells_returned)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase;
    int unsigned count;
    int unsigned frame_len;
    int unsigned density;
    cell_bus.valid      = 1'b0;
    cell_bus.cell_value = 1'b0;
    result_bus.ready    = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = '0;
    cfg_bus.data        = '0;
    rst_ni              = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry 65x65, fill on: into the first result row, with a drain pause at DRAIN_AT
    queue_cells(2 * (cas_pkg::DIM_RESET + cas_pkg::HALO) + 12, 50, FILL_RANDOM, DRAIN_AT);
    wait_idle();

    // out-of-range dimensions saturate to the 5x5 minimum
    write_reg(cas_pkg::REG_GRID_WIDTH, 9'd0);
    write_reg(cas_pkg::REG_GRID_HEIGHT, 9'd3);
    write_reg(cas_pkg::REG_EARLY_FILL, 9'd1);
    queue_cells(49, 0, FILL_ZERO, -1);   // empty grid: sparse rule fills the interior
    queue_cells(49, 0, FILL_ONE, -1);    // solid grid, padding driven high too
    wait_idle();
    write_reg(cas_pkg::REG_EARLY_FILL, 9'h1FE);  // only bit 0 counts
    queue_cells(49, 0, FILL_CHECKER, -1);
    queue_cells(49, 0, FILL_ZERO, -1);
    queue_cells(30, 50, FILL_RANDOM, -1);
    wait_idle();
    write_reg(REG_SPARE, 9'h0AA);       // ignored; frame carries on
    queue_cells(19, 50, FILL_RANDOM, -1);
    queue_cells(20, 50, FILL_RANDOM, -1);
    wait_idle();

    // width above the maximum saturates to 256 columns; run into the first result row
    write_reg(cas_pkg::REG_GRID_WIDTH, 9'd511);
    write_reg(cas_pkg::REG_GRID_HEIGHT, 9'd5);
    @(negedge clk_i);
    queue_cells(2 * (cols_eff + cas_pkg::HALO) + 12, 50, FILL_RANDOM, -1);
    wait_idle();

    phase = 0;
    while (cells_queued < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if (phase == 0 || $urandom_range(0, 2) != 0) begin
        write_reg(cas_pkg::REG_GRID_WIDTH, random_dim());
        write_reg(cas_pkg::REG_GRID_HEIGHT, random_dim());
      end
      if ($urandom_range(0, 1) != 0)
        write_reg(cas_pkg::REG_EARLY_FILL, dim_t'($urandom_range(0, 1)));
      density = $urandom_range(0, 1) ? $urandom_range(0, 12) : $urandom_range(40, 100);
      @(negedge clk_i);
      frame_len = (cols_eff + cas_pkg::HALO) * (rows_eff + cas_pkg::HALO);
      count     = $urandom_range(frame_len, 2 * frame_len);
      if (count > ITEM_TARGET - cells_queued) count = ITEM_TARGET - cells_queued;
      queue_cells(count, density, FILL_RANDOM, -1);
      wait_idle();
      phase++;
    end

    if (smoothed_cells.size() != 0) begin
      $error("%0d predicted cells never returned", smoothed_cells.size());
      mismatches++;
    end
    $display("%0d cells streamed, %0d results checked, %0d full frames, %0d register writes",
             cells_sent, cells_returned, frames_done, reg_writes);
    $display("grids from 5x5 up to 256 columns, early fill on and off, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("tb_cave_automaton_step: clean");
    end else begin
      $display("tb_cave_automaton_step: errors");
    end
    $finish;
  end

endmodule
